// ===== sv/swre_pkg.sv =====
// ----------------------------------------------------------------------------
// swre_pkg: shared types and constants of the stop-and-wait request engine
// Holds the opcode and result-kind codes, the result record and queue sizing.
// ----------------------------------------------------------------------------
package swre_pkg;

   // Request queue sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Result queue sizing (power of two, holds at least two results)
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   // Fixed line constants
   localparam logic [7:0] STAND_ADDR       = 8'h8C;
   localparam logic [7:0] EMPTY_ERROR_CODE = 8'hFF;

   // Input operations
   typedef enum logic [2:0] {
      OP_ENQ_TARGET = 3'd0,
      OP_ENQ_ADDR   = 3'd1,
      OP_FIRE       = 3'd2,
      OP_PACKET     = 3'd3,
      OP_TICK       = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_LINK_UP    = 3'd6,
      OP_LINK_DOWN  = 3'd7
   } opcode_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_ENQ_STATUS = 3'd0,
      KIND_TRANSMIT   = 3'd1,
      KIND_RESPONSE   = 3'd2,
      KIND_ERROR      = 3'd3,
      KIND_UNSOLICITED = 3'd4,
      KIND_FAILED     = 3'd5
   } kind_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_TARGET_ADDR   = 3'd0,
      CSR_RETRY_COUNT   = 3'd1,
      CSR_TIMEOUT_TICKS = 3'd2,
      CSR_DIR_MASK      = 3'd3,
      CSR_ERR_MASK      = 3'd4,
      CSR_PUSH_CYCLE    = 3'd5,
      CSR_PUSH_WATCHDOG = 3'd6,
      CSR_PUSH_SUBSPEED = 3'd7
   } csr_index_type;

   // One result transaction
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_addr;
      logic [7:0]  out_cmd;
      logic [15:0] out_seq;
      logic [15:0] out_payload;
      logic [31:0] out_tag;
      logic [7:0]  error_code;
      logic        accepted;
      logic [31:0] tx_count;
      logic [31:0] rx_count;
      logic        last;
   } rsp_type;

   // Push request into the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_push_type;

endpackage

// ===== sv/swre_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// swre_rsp_fifo: result queue of the request engine
// Takes up to two results per cycle, hands out one per transaction.
// ----------------------------------------------------------------------------
module swre_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  swre_pkg::rsp_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output swre_pkg::rsp_type     rsp_head
);
   import swre_pkg::*;

   rsp_type              mem_ff [RSP_DEPTH];
   rsp_type              head_ff;
   logic [RSP_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RSP_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   // Head and flow control
   assign rsp_valid = (count_ff != '0);
   assign rsp_head  = head_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   // Pointer and count update
   always_comb begin
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      wptr_in  = wptr_ff + RSP_PTR_W'(push.count);
      count_in = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
         count_ff <= count_in;
      end
   end

   // Result storage; the head is read ahead at the next read pointer
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wptr_ff + 1'b1] <= push.second;
      end
      if (push.count != 2'd0 && rptr_in == wptr_ff) begin
         head_ff <= push.first;
      end else if (push.count == 2'd2 && rptr_in == RSP_PTR_W'(wptr_ff + 1'b1)) begin
         head_ff <= push.second;
      end else begin
         head_ff <= mem_ff[rptr_in];
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= RSP_CNT_W'(RSP_DEPTH - 2))
      else $error("result pushed without room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result pop lost");

endmodule

// ===== sv/stop_and_wait_request_engine.sv =====
// A request is registered in the input stage and then in the result queue head before its first result shows.
// Throughput: one request per cycle while each causes at most one result and results are not stalled; the
// single result port, one result per cycle, sets the rate when a request causes two.
// Reset clears the queue, the request in flight, counters and sequence number,
// closes the link and loads the register defaults.
// ----------------------------------------------------------------------------
// stop_and_wait_request_engine: stop-and-wait request master
// Queues requests, sends one at a time, matches replies, retries on timeout
// and filters incoming packets by direction and address.
// ----------------------------------------------------------------------------
module stop_and_wait_request_engine (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_opcode,
   input  logic [7:0]          req_addr,
   input  logic [7:0]          req_cmd,
   input  logic [7:0]          req_flags,
   input  logic [15:0]         req_rx_seq,
   input  logic [15:0]         req_payload_handle,
   input  logic                req_payload_empty,
   input  logic [7:0]          req_payload_first,
   input  logic [31:0]         req_tag,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output swre_pkg::kind_type  rsp_kind,
   output logic [7:0]          rsp_out_addr,
   output logic [7:0]          rsp_out_cmd,
   output logic [15:0]         rsp_out_seq,
   output logic [15:0]         rsp_out_payload,
   output logic [31:0]         rsp_out_tag,
   output logic [7:0]          rsp_error_code,
   output logic                rsp_accepted,
   output logic [31:0]         rsp_tx_count,
   output logic [31:0]         rsp_rx_count,
   output logic                rsp_last
);
   import swre_pkg::*;

   typedef struct packed {
      logic [7:0]  addr;
      logic [7:0]  cmd;
      logic [15:0] seq;
      logic [15:0] payload;
      logic [31:0] tag;
   } qent_type;

   function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Configuration registers
   logic [7:0]  target_addr_ff;
   logic [3:0]  retry_count_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  dir_mask_ff, err_mask_ff;
   logic [7:0]  push_cycle_ff, push_wdog_ff, push_sub_ff;

   // Input stage
   logic        s_valid_ff;
   opcode_type  s_op_ff;
   logic [7:0]  s_addr_ff, s_cmd_ff, s_flags_ff, s_first_ff;
   logic [15:0] s_rseq_ff, s_pay_ff;
   logic        s_empty_ff;
   logic [31:0] s_tag_ff;

   // Engine state
   qent_type           q_mem_ff [QUEUE_DEPTH];
   qent_type           q_head_ff;
   logic [QPTR_W-1:0]  q_rptr_ff, q_rptr_in, q_wptr_ff, q_wptr_in;
   logic [QFILL_W-1:0] q_fill_ff, q_fill_in;
   logic               q_write;
   qent_type           q_wdata;
   qent_type           cur_ff, cur_in;
   logic [3:0]         attempts_ff, attempts_in;
   logic               in_flight_ff, in_flight_in;
   logic [15:0]        wait_ff, wait_in;
   logic [15:0]        next_seq_ff, next_seq_in;
   logic               link_ff, link_in;
   logic [31:0]        sent_ff, sent_in, rcvd_ff, rcvd_in;

   // Step control
   logic         room;
   logic         advance;
   logic         try_start;
   logic         bypass;
   logic [7:0]   dst;
   logic         dir_ok, addr_ok, push_hit, reply_hit;
   rsp_push_type push;
   rsp_type      rsp_head;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_addr_ff <= 8'd0;
         retry_count_ff <= 4'd2;
         timeout_ff     <= 16'd500;
         dir_mask_ff    <= 8'd1;
         err_mask_ff    <= 8'd2;
         push_cycle_ff  <= 8'd0;
         push_wdog_ff   <= 8'd0;
         push_sub_ff    <= 8'd0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_ADDR:   target_addr_ff <= csr_data[7:0];
            CSR_RETRY_COUNT:   retry_count_ff <= csr_data[3:0];
            CSR_TIMEOUT_TICKS: timeout_ff     <= csr_data;
            CSR_DIR_MASK:      dir_mask_ff    <= csr_data[7:0];
            CSR_ERR_MASK:      err_mask_ff    <= csr_data[7:0];
            CSR_PUSH_CYCLE:    push_cycle_ff  <= csr_data[7:0];
            CSR_PUSH_WATCHDOG: push_wdog_ff   <= csr_data[7:0];
            CSR_PUSH_SUBSPEED: push_sub_ff    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: processed once the result queue has room for two
   assign advance   = s_valid_ff && room;
   assign req_stall = s_valid_ff && !room;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s_op_ff    <= opcode_type'(req_opcode);
         s_addr_ff  <= req_addr;
         s_cmd_ff   <= req_cmd;
         s_flags_ff <= req_flags;
         s_rseq_ff  <= req_rx_seq;
         s_pay_ff   <= req_payload_handle;
         s_empty_ff <= req_payload_empty;
         s_first_ff <= req_payload_first;
         s_tag_ff   <= req_tag;
      end
   end

   // Packet filters
   assign dst       = (s_op_ff == OP_ENQ_TARGET) ? target_addr_ff : s_addr_ff;
   assign dir_ok    = (s_flags_ff & dir_mask_ff) != 8'd0;
   assign addr_ok   = (s_addr_ff == target_addr_ff) || (s_addr_ff == STAND_ADDR);
   assign push_hit  = (s_addr_ff == target_addr_ff) &&
                      ((s_cmd_ff == push_cycle_ff) || (s_cmd_ff == push_wdog_ff) ||
                       (s_cmd_ff == push_sub_ff));
   assign reply_hit = in_flight_ff && (s_rseq_ff == cur_ff.seq) &&
                      (s_cmd_ff == cur_ff.cmd) && (s_addr_ff == cur_ff.addr);

   // One step of the engine
   always_comb begin
      q_rptr_in    = q_rptr_ff;
      q_wptr_in    = q_wptr_ff;
      q_fill_in    = q_fill_ff;
      q_write      = 1'b0;
      q_wdata      = '{addr: dst, cmd: s_cmd_ff, seq: next_seq_ff,
                       payload: s_pay_ff, tag: s_tag_ff};
      cur_in       = cur_ff;
      attempts_in  = attempts_ff;
      in_flight_in = in_flight_ff;
      wait_in      = wait_ff;
      next_seq_in  = next_seq_ff;
      link_in      = link_ff;
      sent_in      = sent_ff;
      rcvd_in      = rcvd_ff;
      push         = '0;
      try_start    = 1'b0;
      bypass       = 1'b0;

      if (advance) begin
         case (s_op_ff)
            OP_ENQ_TARGET, OP_ENQ_ADDR: begin
               push.count          = 2'd1;
               push.first.kind     = KIND_ENQ_STATUS;
               push.first.out_addr = dst;
               push.first.out_cmd  = s_cmd_ff;
               if (link_ff && q_fill_ff != QFILL_W'(QUEUE_DEPTH)) begin
                  q_write              = 1'b1;
                  bypass               = (q_fill_ff == '0);
                  q_wptr_in            = qptr_next(q_wptr_ff);
                  q_fill_in            = q_fill_ff + 1'b1;
                  next_seq_in          = next_seq_ff + 1'b1;
                  push.first.out_seq   = next_seq_ff;
                  push.first.accepted  = 1'b1;
                  try_start            = 1'b1;
               end
            end
            OP_FIRE: begin
               if (link_ff) begin
                  sent_in                = sent_ff + 1'b1;
                  next_seq_in            = next_seq_ff + 1'b1;
                  push.count             = 2'd1;
                  push.first.kind        = KIND_TRANSMIT;
                  push.first.out_addr    = s_addr_ff;
                  push.first.out_cmd     = s_cmd_ff;
                  push.first.out_seq     = next_seq_ff;
                  push.first.out_payload = s_pay_ff;
               end
            end
            OP_PACKET: begin
               if (dir_ok && addr_ok) begin
                  rcvd_in             = rcvd_ff + 1'b1;
                  push.first.out_addr = s_addr_ff;
                  push.first.out_cmd  = s_cmd_ff;
                  push.first.out_seq  = s_rseq_ff;
                  if (push_hit) begin
                     push.count             = 2'd1;
                     push.first.kind        = KIND_UNSOLICITED;
                     push.first.out_payload = s_pay_ff;
                  end else if (reply_hit) begin
                     push.count   = 2'd1;
                     in_flight_in = 1'b0;
                     try_start    = 1'b1;
                     if ((s_flags_ff & err_mask_ff) != 8'd0) begin
                        push.first.kind       = KIND_ERROR;
                        push.first.error_code = s_empty_ff ? EMPTY_ERROR_CODE : s_first_ff;
                     end else begin
                        push.first.kind        = KIND_RESPONSE;
                        push.first.out_payload = s_pay_ff;
                        push.first.out_tag     = cur_ff.tag;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (in_flight_ff) begin
                  if (wait_ff > 16'd1) begin
                     wait_in = wait_ff - 1'b1;
                  end else begin
                     wait_in             = 16'd0;
                     push.count          = 2'd1;
                     push.first.out_addr = cur_ff.addr;
                     push.first.out_cmd  = cur_ff.cmd;
                     push.first.out_seq  = cur_ff.seq;
                     if (attempts_ff != 4'd0) begin
                        // retransmit with the same sequence number
                        attempts_in            = attempts_ff - 1'b1;
                        sent_in                = sent_ff + 1'b1;
                        wait_in                = timeout_ff;
                        push.first.kind        = KIND_TRANSMIT;
                        push.first.out_payload = cur_ff.payload;
                     end else begin
                        push.first.kind = KIND_FAILED;
                        in_flight_in    = 1'b0;
                        try_start       = 1'b1;
                     end
                  end
               end
            end
            OP_CLEAR, OP_LINK_DOWN: begin
               q_rptr_in    = '0;
               q_wptr_in    = '0;
               q_fill_in    = '0;
               in_flight_in = 1'b0;
               wait_in      = 16'd0;
               if (s_op_ff == OP_LINK_DOWN) begin
                  link_in = 1'b0;
               end
            end
            OP_LINK_UP: begin
               link_in = 1'b1;
            end
            default: begin
            end
         endcase

         // Send the next queued request as the second result
         if (try_start && !in_flight_in && q_fill_in != '0 && link_ff) begin
            cur_in                  = bypass ? q_wdata : q_head_ff;
            q_rptr_in               = qptr_next(q_rptr_ff);
            q_fill_in               = q_fill_in - 1'b1;
            in_flight_in            = 1'b1;
            attempts_in             = retry_count_ff;
            sent_in                 = sent_in + 1'b1;
            wait_in                 = timeout_ff;
            push.count              = 2'd2;
            push.second.kind        = KIND_TRANSMIT;
            push.second.out_addr    = cur_in.addr;
            push.second.out_cmd     = cur_in.cmd;
            push.second.out_seq     = cur_in.seq;
            push.second.out_payload = cur_in.payload;
            push.second.tx_count    = sent_in;
            push.second.rx_count    = rcvd_in;
            push.second.last        = 1'b1;
         end

         // Totals as seen by the first result
         if (push.count == 2'd2) begin
            push.first.tx_count = sent_ff;
         end else begin
            push.first.tx_count = sent_in;
         end
         push.first.rx_count = rcvd_in;
         push.first.last     = (push.count == 2'd1);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_rptr_ff    <= '0;
         q_wptr_ff    <= '0;
         q_fill_ff    <= '0;
         attempts_ff  <= 4'd0;
         in_flight_ff <= 1'b0;
         wait_ff      <= 16'd0;
         next_seq_ff  <= 16'd0;
         link_ff      <= 1'b0;
         sent_ff      <= 32'd0;
         rcvd_ff      <= 32'd0;
      end else begin
         q_rptr_ff    <= q_rptr_in;
         q_wptr_ff    <= q_wptr_in;
         q_fill_ff    <= q_fill_in;
         attempts_ff  <= attempts_in;
         in_flight_ff <= in_flight_in;
         wait_ff      <= wait_in;
         next_seq_ff  <= next_seq_in;
         link_ff      <= link_in;
         sent_ff      <= sent_in;
         rcvd_ff      <= rcvd_in;
      end
   end

   // Request in flight and queue storage; the queue head is read ahead
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (q_write) begin
         q_mem_ff[q_wptr_ff] <= q_wdata;
      end
      if (q_write && q_wptr_ff == q_rptr_in) begin
         q_head_ff <= q_wdata;
      end else begin
         q_head_ff <= q_mem_ff[q_rptr_in];
      end
   end

   // Result queue
   swre_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_head  (rsp_head)
   );

   assign rsp_kind        = rsp_head.kind;
   assign rsp_out_addr    = rsp_head.out_addr;
   assign rsp_out_cmd     = rsp_head.out_cmd;
   assign rsp_out_seq     = rsp_head.out_seq;
   assign rsp_out_payload = rsp_head.out_payload;
   assign rsp_out_tag     = rsp_head.out_tag;
   assign rsp_error_code  = rsp_head.error_code;
   assign rsp_accepted    = rsp_head.accepted;
   assign rsp_tx_count    = rsp_head.tx_count;
   assign rsp_rx_count    = rsp_head.rx_count;
   assign rsp_last        = rsp_head.last;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("request queue fill beyond depth");

   a_flight_needs_link: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff |-> link_ff)
      else $error("request in flight with link closed");

   a_link_down_drops: assert property (@(posedge clock) disable iff (reset)
      advance && s_op_ff == OP_LINK_DOWN |=> q_fill_ff == '0 && !in_flight_ff && !link_ff)
      else $error("link down left work behind");

   a_one_send_per_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (sent_ff - $past(sent_ff)) <= 32'd1)
      else $error("more than one packet sent in a step");

endmodule
